// ----- rtl/packet_payload_ascii_capper_macros.svh -----
// assertion macros shared by the capper rtl
`ifndef PACKET_PAYLOAD_ASCII_CAPPER_MACROS_SVH
`define PACKET_PAYLOAD_ASCII_CAPPER_MACROS_SVH
`ifndef SYNTHESIS
// plain property, checked on every rising clock edge outside reset
`define PPAC_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("ppac assertion failed");
// overlapped implication
`define PPAC_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("ppac implication failed");
`else
`define PPAC_ASSERT(lbl, prop)
`define PPAC_ASSERT_IMP(lbl, ante, cons)
`endif
`endif

// ----- rtl/ppac_pkg.sv -----
package ppac_pkg;

  // verdict codes
  typedef enum logic [1:0] {
    V_KEEP  = 2'd0,
    V_CAP   = 2'd1,
    V_UNSUP = 2'd2,
    V_ILL   = 2'd3
  } verdict_e;

  localparam int unsigned LEN_W = 16;  // frame length never exceeds 65535
  localparam int unsigned CAP_W = 15;

  // header parsing constants
  localparam logic [15:0] ETH_TYPE_VLAN = 16'h8100;
  localparam logic [15:0] ETH_TYPE_IPV4 = 16'h0800;
  localparam int unsigned ETH_TYPE_OFS  = 12;
  localparam int unsigned ETH_HDR_LEN   = 14;
  localparam int unsigned VLAN_TAG_LEN  = 4;
  localparam int unsigned IP_MIN_HDR    = 20;
  localparam int unsigned IP_PROTO_OFS  = 9;
  localparam logic [7:0]  IP_PROTO_UDP  = 8'd17;
  localparam logic [7:0]  IP_PROTO_TCP  = 8'd6;
  localparam int unsigned UDP_HDR_LEN   = 8;
  localparam int unsigned TCP_DOFF_OFS  = 12;
  localparam logic [3:0]  TCP_MIN_DOFF  = 4'd5;
  localparam int unsigned PCT_SCALE     = 100;

  // configuration as seen by the datapath
  typedef struct packed {
    logic [7:0]  printable_low;
    logic [7:0]  printable_high;
    logic [14:0] run_threshold;
    logic [6:0]  text_percent;
  } cfg_t;

  // per-frame summary handed from parser to verdict unit
  typedef struct packed {
    logic             pend;     // share test still to be made
    verdict_e         verdict;  // final verdict when not pending
    logic [CAP_W-1:0] header;
    logic [LEN_W-1:0] len;
    logic [LEN_W-1:0] count;
  } frame_rec_t;

endpackage

// ----- rtl/ppac_fifo.sv -----
module ppac_fifo #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 4
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] data_i,
  input  logic             pop_i,
  output logic [WIDTH-1:0] data_o,
  output logic             empty_o,
  output logic             full_o
);
`include "packet_payload_ascii_capper_macros.svh"

  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [PW-1:0]    wr_q, wr_d, rd_q, rd_d;
  logic [CW-1:0]    cnt_q, cnt_d;

  assign empty_o = (cnt_q == '0);
  assign full_o  = (cnt_q == CW'(DEPTH));
  assign data_o  = mem_q[rd_q];

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (push_i) begin
      wr_d = (wr_q == PW'(DEPTH - 1)) ? '0 : wr_q + 1'b1;
    end
    if (pop_i) begin
      rd_d = (rd_q == PW'(DEPTH - 1)) ? '0 : rd_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= data_i;
    end
  end

  `PPAC_ASSERT(a_fifo_no_overflow, !(push_i && full_o))
  `PPAC_ASSERT(a_fifo_no_underflow, !(pop_i && empty_o))

endmodule

// ----- rtl/ppac_front.sv -----
module ppac_front #(
  parameter int unsigned MAX_FRAME_BYTES = 16384
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                accept_i,
  input  logic [7:0]          data_byte_i,
  input  logic                last_byte_i,
  input  ppac_pkg::cfg_t      cfg_i,
  output logic                push_o,
  output ppac_pkg::frame_rec_t rec_o
);
`include "packet_payload_ascii_capper_macros.svh"

  localparam int unsigned W  = $clog2(MAX_FRAME_BYTES + 1);
  localparam int unsigned HW = $clog2(MAX_FRAME_BYTES + 128);
  localparam int unsigned CW = (W > 15) ? W : 15;

  typedef enum logic [1:0] {
    PH_TAG,
    PH_IP,
    PH_TCP,
    PH_PAY
  } phase_e;

  phase_e             phase_q, phase_n, phase_d;
  logic [W-1:0]       off_q, off_n, off_d;
  logic [HW-1:0]      hdr_q, hdr_n, hdr_d;
  logic [7:0]         hold_q, hold_n, hold_d;
  logic [7:0]         proto_q, proto_n, proto_d;
  logic [W-1:0]       run_q, run_n, run_d;
  logic [W-1:0]       cnt_q, cnt_n, cnt_d;
  logic               early_q, early_n, early_d;
  ppac_pkg::verdict_e ev_q, ev_n, ev_d;

  logic [HW-1:0] pos;
  logic          in_span;
  logic          printable;
  logic          pay_ok;

  assign pos       = HW'(off_q);
  assign in_span   = (off_q < W'(MAX_FRAME_BYTES));
  assign printable = (data_byte_i >= cfg_i.printable_low) &&
                     (data_byte_i <= cfg_i.printable_high);

  // byte step
  always_comb begin
    phase_n = phase_q;
    off_n   = off_q;
    hdr_n   = hdr_q;
    hold_n  = hold_q;
    proto_n = proto_q;
    run_n   = run_q;
    cnt_n   = cnt_q;
    early_n = early_q;
    ev_n    = ev_q;
    if (in_span) begin
      off_n = off_q + 1'b1;
      if (!early_q) begin
        case (phase_q)
          PH_TAG: begin
            if (pos == hdr_q + HW'(ppac_pkg::ETH_TYPE_OFS)) begin
              hold_n = data_byte_i;
            end else if (pos == hdr_q + HW'(ppac_pkg::ETH_TYPE_OFS + 1)) begin
              if ({hold_q, data_byte_i} == ppac_pkg::ETH_TYPE_VLAN) begin
                hdr_n = hdr_q + HW'(ppac_pkg::VLAN_TAG_LEN);
              end else if ({hold_q, data_byte_i} == ppac_pkg::ETH_TYPE_IPV4) begin
                hdr_n   = hdr_q + HW'(ppac_pkg::ETH_HDR_LEN);
                phase_n = PH_IP;
              end else begin
                early_n = 1'b1;
                ev_n    = ppac_pkg::V_UNSUP;
              end
            end
          end
          PH_IP: begin
            if (pos == hdr_q) begin
              hold_n = {2'b00, data_byte_i[3:0], 2'b00};
              if ({2'b00, data_byte_i[3:0], 2'b00} < 8'(ppac_pkg::IP_MIN_HDR)) begin
                early_n = 1'b1;
                ev_n    = ppac_pkg::V_ILL;
              end
            end else if (pos == hdr_q + HW'(ppac_pkg::IP_PROTO_OFS)) begin
              proto_n = data_byte_i;
            end else if (pos == hdr_q + HW'(hold_q) - 1'b1) begin
              if (proto_q == ppac_pkg::IP_PROTO_UDP) begin
                hdr_n   = hdr_q + HW'(hold_q) + HW'(ppac_pkg::UDP_HDR_LEN);
                phase_n = PH_PAY;
              end else if (proto_q == ppac_pkg::IP_PROTO_TCP) begin
                hdr_n   = hdr_q + HW'(hold_q);
                phase_n = PH_TCP;
              end else begin
                hdr_n   = hdr_q + HW'(hold_q);
                early_n = 1'b1;
                ev_n    = ppac_pkg::V_UNSUP;
              end
            end
          end
          PH_TCP: begin
            if (pos == hdr_q + HW'(ppac_pkg::TCP_DOFF_OFS)) begin
              if (data_byte_i[7:4] < ppac_pkg::TCP_MIN_DOFF) begin
                early_n = 1'b1;
                ev_n    = ppac_pkg::V_ILL;
              end else begin
                hdr_n   = hdr_q + HW'({data_byte_i[7:4], 2'b00});
                phase_n = PH_PAY;
              end
            end
          end
          PH_PAY: begin
            if (pos >= hdr_q) begin
              if (printable) begin
                run_n = run_q + 1'b1;
                cnt_n = cnt_q + 1'b1;
                if ((cfg_i.run_threshold != '0) &&
                    (CW'(run_q + 1'b1) == CW'(cfg_i.run_threshold))) begin
                  early_n = 1'b1;
                  ev_n    = ppac_pkg::V_KEEP;
                end
              end else begin
                run_n = '0;
              end
            end
          end
          default: ;
        endcase
      end
    end
  end

  // frame summary from the state after the last byte
  assign pay_ok = (phase_n == PH_PAY) && (hdr_n < HW'(off_n));

  always_comb begin
    rec_o.pend    = !early_n && pay_ok;
    rec_o.verdict = early_n ? ev_n : ppac_pkg::V_ILL;
    rec_o.header  = ppac_pkg::CAP_W'(hdr_n);
    rec_o.len     = ppac_pkg::LEN_W'(off_n);
    rec_o.count   = ppac_pkg::LEN_W'(cnt_n);
  end

  assign push_o = accept_i && last_byte_i;

  always_comb begin
    if (last_byte_i) begin
      phase_d = PH_TAG;
      off_d   = '0;
      hdr_d   = '0;
      hold_d  = '0;
      proto_d = '0;
      run_d   = '0;
      cnt_d   = '0;
      early_d = 1'b0;
      ev_d    = ppac_pkg::V_KEEP;
    end else begin
      phase_d = phase_n;
      off_d   = off_n;
      hdr_d   = hdr_n;
      hold_d  = hold_n;
      proto_d = proto_n;
      run_d   = run_n;
      cnt_d   = cnt_n;
      early_d = early_n;
      ev_d    = ev_n;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_TAG;
      off_q   <= '0;
      hdr_q   <= '0;
      hold_q  <= '0;
      proto_q <= '0;
      run_q   <= '0;
      cnt_q   <= '0;
      early_q <= 1'b0;
      ev_q    <= ppac_pkg::V_KEEP;
    end else if (accept_i) begin
      phase_q <= phase_d;
      off_q   <= off_d;
      hdr_q   <= hdr_d;
      hold_q  <= hold_d;
      proto_q <= proto_d;
      run_q   <= run_d;
      cnt_q   <= cnt_d;
      early_q <= early_d;
      ev_q    <= ev_d;
    end
  end

  `PPAC_ASSERT(a_hdr_bound, hdr_q <= HW'(MAX_FRAME_BYTES + 64))
  `PPAC_ASSERT(a_early_freeze, ((early_q && !(accept_i && last_byte_i)) |=> $stable(phase_q)))

endmodule

// ----- rtl/ppac_back.sv -----
module ppac_back (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               rec_valid_i,
  input  ppac_pkg::frame_rec_t               rec_i,
  input  logic [6:0]                         text_percent_i,
  output logic                               pop_o,
  output logic                               out_valid_o,
  input  logic                               out_stall_i,
  output logic [1:0]                         verdict_o,
  output logic [ppac_pkg::CAP_W-1:0]         cap_length_o
);
`include "packet_payload_ascii_capper_macros.svh"

  localparam int unsigned PW = ppac_pkg::LEN_W + 7;

  // product stage
  logic                       s1_valid_q;
  logic                       s1_pend_q;
  ppac_pkg::verdict_e         s1_v_q;
  logic [ppac_pkg::CAP_W-1:0] s1_hdr_q;
  logic [ppac_pkg::CAP_W-1:0] s1_len_q;
  logic [PW-1:0]              s1_a_q;
  logic [PW-1:0]              s1_b_q;

  // output register
  logic                       out_valid_q;
  ppac_pkg::verdict_e         verdict_q, verdict_d;
  logic [ppac_pkg::CAP_W-1:0] cap_q, cap_d;

  logic out_load;
  logic share_ok;

  assign out_load = !out_valid_q || !out_stall_i;
  assign pop_o    = rec_valid_i && (!s1_valid_q || out_load);
  assign share_ok = (s1_a_q >= s1_b_q);

  always_comb begin
    if (s1_pend_q) begin
      verdict_d = share_ok ? ppac_pkg::V_KEEP : ppac_pkg::V_CAP;
      cap_d     = share_ok ? s1_len_q : s1_hdr_q;
    end else begin
      verdict_d = s1_v_q;
      cap_d     = s1_len_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (pop_o) begin
        s1_valid_q <= 1'b1;
      end else if (out_load) begin
        s1_valid_q <= 1'b0;
      end
      if (out_load) begin
        out_valid_q <= s1_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      s1_pend_q <= rec_i.pend;
      s1_v_q    <= rec_i.verdict;
      s1_hdr_q  <= rec_i.header;
      s1_len_q  <= ppac_pkg::CAP_W'(rec_i.len);
      s1_a_q    <= PW'(rec_i.count) * PW'(ppac_pkg::PCT_SCALE);
      s1_b_q    <= PW'(text_percent_i) * PW'(rec_i.len);
    end
    if (out_load && s1_valid_q) begin
      verdict_q <= verdict_d;
      cap_q     <= cap_d;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign verdict_o    = verdict_q;
  assign cap_length_o = cap_q;

  `PPAC_ASSERT_IMP(a_s1_hold, s1_valid_q && out_valid_q && out_stall_i,
                   ##1 (s1_valid_q && $stable(s1_a_q) && $stable(s1_b_q)))

endmodule

// ----- rtl/packet_payload_ascii_capper.sv -----
// a frame's summary passes the summary queue, the product stage and the output register in turn
// throughput: one frame byte per cycle while the summary queue is not full
// a four-entry summary queue lets the parser run on while the output is stalled
// reset: rst_ni is asynchronous, active low; parser, queue and output go empty,
// registers return to 32, 126, 8 and 50
module packet_payload_ascii_capper #(
  parameter int unsigned MAX_FRAME_BYTES = 16384
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  // byte stream
  input  logic                       in_valid_i,
  output logic                       in_stall_o,
  input  logic [7:0]                 data_byte_i,
  input  logic                       last_byte_i,
  // verdict stream
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output logic [1:0]                 verdict_o,
  output logic [ppac_pkg::CAP_W-1:0] cap_length_o,
  // register port
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [3:0]                 paddr,
  input  logic [31:0]                pwdata,
  output logic [31:0]                prdata,
  output logic                       pready
);

  localparam int unsigned QDEPTH = 4;

  // register indices (word address)
  localparam logic [1:0] REG_PRINT_LOW  = 2'd0;
  localparam logic [1:0] REG_PRINT_HIGH = 2'd1;
  localparam logic [1:0] REG_RUN_THR    = 2'd2;
  localparam logic [1:0] REG_TEXT_PCT   = 2'd3;

  ppac_pkg::cfg_t       cfg_q;
  ppac_pkg::frame_rec_t front_rec;
  ppac_pkg::frame_rec_t q_rec;
  logic                 wr_en;
  logic                 accept;
  logic                 push;
  logic                 pop;
  logic                 q_empty;
  logic                 q_full;

  // ---------------------------------------------------------------------------
  // register port: zero wait state, decode on the word address only
  // ---------------------------------------------------------------------------
  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.printable_low  <= 8'd32;
      cfg_q.printable_high <= 8'd126;
      cfg_q.run_threshold  <= 15'd8;
      cfg_q.text_percent   <= 7'd50;
    end else if (wr_en) begin
      case (paddr[3:2])
        REG_PRINT_LOW:  cfg_q.printable_low  <= pwdata[7:0];
        REG_PRINT_HIGH: cfg_q.printable_high <= pwdata[7:0];
        REG_RUN_THR:    cfg_q.run_threshold  <= pwdata[14:0];
        REG_TEXT_PCT:   cfg_q.text_percent   <= pwdata[6:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      REG_PRINT_LOW:  prdata = {24'd0, cfg_q.printable_low};
      REG_PRINT_HIGH: prdata = {24'd0, cfg_q.printable_high};
      REG_RUN_THR:    prdata = {17'd0, cfg_q.run_threshold};
      REG_TEXT_PCT:   prdata = {25'd0, cfg_q.text_percent};
      default:        prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------------------
  // front: header parse and payload counting, one byte per transaction;
  // the byte stream stalls only when the summary queue is full
  // ---------------------------------------------------------------------------
  assign in_stall_o = q_full;
  assign accept     = in_valid_i && !in_stall_o;

  ppac_front #(
    .MAX_FRAME_BYTES(MAX_FRAME_BYTES)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .accept_i    (accept),
    .data_byte_i (data_byte_i),
    .last_byte_i (last_byte_i),
    .cfg_i       (cfg_q),
    .push_o      (push),
    .rec_o       (front_rec)
  );

  // ---------------------------------------------------------------------------
  // per-frame summary queue between parser and verdict unit
  // ---------------------------------------------------------------------------
  ppac_fifo #(
    .WIDTH($bits(ppac_pkg::frame_rec_t)),
    .DEPTH(QDEPTH)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (front_rec),
    .pop_i   (pop),
    .data_o  (q_rec),
    .empty_o (q_empty),
    .full_o  (q_full)
  );

  // ---------------------------------------------------------------------------
  // back: share test products are registered, then compared into the
  // output register which holds the result while the sink stalls
  // ---------------------------------------------------------------------------
  ppac_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .rec_valid_i    (!q_empty),
    .rec_i          (q_rec),
    .text_percent_i (cfg_q.text_percent),
    .pop_o          (pop),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .verdict_o      (verdict_o),
    .cap_length_o   (cap_length_o)
  );

endmodule

// ----- verif/tb_packet_payload_ascii_capper.sv -----
`timescale 1ns / 100ps

module tb_packet_payload_ascii_capper;

  // ---------------------------------------------------------------------------
  // constants
  // ---------------------------------------------------------------------------
  localparam int unsigned FRAME_LIMIT  = 16384;  // byte budget of one frame
  localparam int unsigned REG_STRIDE   = 4;      // byte distance between registers
  localparam int unsigned MAX_GAP      = 11;     // longest random idle or stall
  localparam int unsigned LONG_HOLD    = 400;    // receiver hold-off, in cycles
  localparam int unsigned DRAIN_CYCLES = 4;      // verdict latency plus margin
  localparam int unsigned PHASE_BYTES  = 70;     // random bytes per register setting
  localparam int unsigned PHASE_FRAMES = 1;      // and at least this many frames
  localparam int unsigned NUM_PHASES   = 7;

  // register map, in address order
  typedef enum int unsigned {
    REG_PRINT_LOW  = 0,
    REG_PRINT_HIGH = 1,
    REG_RUN_LIMIT  = 2,
    REG_TEXT_PCT   = 3
  } capper_reg_e;

  // parser position within the frame
  typedef enum logic [1:0] {
    PH_TAG,
    PH_IP,
    PH_TCP,
    PH_PAYLOAD
  } parse_phase_e;

  // one verdict transaction as the block should present it
  typedef struct {
    ppac_pkg::verdict_e verdict;
    logic [14:0]        cap_length;
  } verdict_rec_t;

  // ---------------------------------------------------------------------------
  // verdict scoreboard: parses the byte stream alongside the block and keeps
  // the verdicts it owes, oldest first
  // ---------------------------------------------------------------------------
  class capper_scoreboard;
    logic [7:0]   print_lo;
    logic [7:0]   print_hi;
    logic [14:0]  run_limit;
    logic [6:0]   share_pct;

    logic [15:0]  offset;
    logic [15:0]  hdr_len;
    logic [15:0]  run_len;
    logic [15:0]  text_count;
    logic [7:0]   hold;
    logic [7:0]   proto;
    parse_phase_e phase;
    bit           decided;
    ppac_pkg::verdict_e early;

    verdict_rec_t verdict_q[$];
    int           errors;

    function new();
      print_lo  = 8'd32;
      print_hi  = 8'd126;
      run_limit = 15'd8;
      share_pct = 7'd50;
      errors    = 0;
      clear_frame();
    endfunction

    function void clear_frame();
      offset     = '0;
      hdr_len    = '0;
      run_len    = '0;
      text_count = '0;
      hold       = '0;
      proto      = '0;
      phase      = PH_TAG;
      decided    = 1'b0;
      early      = ppac_pkg::V_KEEP;
    endfunction

    function void decide(ppac_pkg::verdict_e v);
      decided = 1'b1;
      early   = v;
    endfunction

    function void set_reg(capper_reg_e idx, logic [31:0] value);
      case (idx)
        REG_PRINT_LOW:  print_lo  = value[7:0];
        REG_PRINT_HIGH: print_hi  = value[7:0];
        REG_RUN_LIMIT:  run_limit = value[14:0];
        REG_TEXT_PCT:   share_pct = value[6:0];
        default: ;
      endcase
    endfunction

    function int pending();
      return verdict_q.size();
    endfunction

    // one accepted byte transaction
    function void note_byte(logic [7:0] b, logic last);
      logic [15:0]        pos;
      logic [15:0]        len;
      logic [14:0]        cap;
      ppac_pkg::verdict_e verdict;
      verdict_rec_t       rec;
      if (offset < FRAME_LIMIT) begin
        pos = offset;
        offset++;
        if (!decided) begin
          case (phase)
            PH_TAG: begin
              if (pos == hdr_len + ppac_pkg::ETH_TYPE_OFS) begin
                hold = b;
              end else if (pos == hdr_len + ppac_pkg::ETH_TYPE_OFS + 1) begin
                if ({hold, b} == ppac_pkg::ETH_TYPE_VLAN) begin
                  hdr_len += 16'(ppac_pkg::VLAN_TAG_LEN);
                end else if ({hold, b} == ppac_pkg::ETH_TYPE_IPV4) begin
                  hdr_len += 16'(ppac_pkg::ETH_HDR_LEN);
                  phase = PH_IP;
                end else begin
                  decide(ppac_pkg::V_UNSUP);
                end
              end
            end
            PH_IP: begin
              if (pos == hdr_len) begin
                hold = {2'b00, b[3:0], 2'b00};
                if (hold < ppac_pkg::IP_MIN_HDR) decide(ppac_pkg::V_ILL);
              end else if (pos == hdr_len + ppac_pkg::IP_PROTO_OFS) begin
                proto = b;
              end else if (pos == hdr_len + hold - 1) begin
                hdr_len += 16'(hold);
                if (proto == ppac_pkg::IP_PROTO_UDP) begin
                  hdr_len += 16'(ppac_pkg::UDP_HDR_LEN);
                  phase = PH_PAYLOAD;
                end else if (proto == ppac_pkg::IP_PROTO_TCP) begin
                  phase = PH_TCP;
                end else begin
                  decide(ppac_pkg::V_UNSUP);
                end
              end
            end
            PH_TCP: begin
              if (pos == hdr_len + ppac_pkg::TCP_DOFF_OFS) begin
                if (b[7:4] < ppac_pkg::TCP_MIN_DOFF) begin
                  decide(ppac_pkg::V_ILL);
                end else begin
                  hdr_len += 16'({b[7:4], 2'b00});
                  phase = PH_PAYLOAD;
                end
              end
            end
            default: begin
              if (pos >= hdr_len) begin
                if (b >= print_lo && b <= print_hi) begin
                  run_len++;
                  text_count++;
                  if (run_limit != 0 && run_len == run_limit) decide(ppac_pkg::V_KEEP);
                end else begin
                  run_len = '0;
                end
              end
            end
          endcase
        end
      end
      if (last) begin
        len = offset;
        cap = len[14:0];
        if (decided) begin
          verdict = early;
        end else if (phase != PH_PAYLOAD || hdr_len >= len) begin
          verdict = ppac_pkg::V_ILL;
        end else if (32'(text_count) * ppac_pkg::PCT_SCALE >=
                     32'(share_pct) * 32'(len)) begin
          verdict = ppac_pkg::V_KEEP;
        end else begin
          verdict = ppac_pkg::V_CAP;
          cap     = hdr_len[14:0];
        end
        rec.verdict    = verdict;
        rec.cap_length = cap;
        verdict_q.push_back(rec);
        clear_frame();
      end
    endfunction

    // one accepted verdict transaction
    function void check_verdict(logic [1:0] verdict, logic [14:0] cap_length);
      verdict_rec_t rec;
      if (verdict_q.size() == 0) begin
        $error("verdict transaction with none owed: verdict %0d, cap_length %0d",
               verdict, cap_length);
        errors++;
        return;
      end
      rec = verdict_q.pop_front();
      if (verdict != rec.verdict) begin
        $error("verdict: expected %0d, actual %0d", rec.verdict, verdict);
        errors++;
      end
      if (cap_length != rec.cap_length) begin
        $error("cap_length: expected %0d, actual %0d", rec.cap_length, cap_length);
        errors++;
      end
    endfunction
  endclass

  // ---------------------------------------------------------------------------
  // block signals, inputs all driven to known values from time zero
  // ---------------------------------------------------------------------------
  logic        clk_i       = 1'b0;
  logic        rst_ni      = 1'b0;
  logic        in_valid_i  = 1'b0;
  logic        in_stall_o;
  logic [7:0]  data_byte_i = 8'h00;
  logic        last_byte_i = 1'b0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic [1:0]  verdict_o;
  logic [ppac_pkg::CAP_W-1:0] cap_length_o;
  logic        psel        = 1'b0;
  logic        penable     = 1'b0;
  logic        pwrite      = 1'b0;
  logic [3:0]  paddr       = 4'h0;
  logic [31:0] pwdata      = 32'h0;
  logic [31:0] prdata;
  logic        pready;

  capper_scoreboard sb = new();

  logic [7:0] frame_q[$];       // bytes of the frame being built
  bit         calm          = 1'b0;  // no idling on either side
  bit         hold_off_req  = 1'b0;  // ask the receiver for a long hold-off
  bit         took_result   = 1'b0;  // receiver accepted a verdict

  packet_payload_ascii_capper #(
    .MAX_FRAME_BYTES(FRAME_LIMIT)
  ) dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .data_byte_i  (data_byte_i),
    .last_byte_i  (last_byte_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .verdict_o    (verdict_o),
    .cap_length_o (cap_length_o),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready)
  );

  // 8 ns clock
  initial begin
    forever #4 clk_i = ~clk_i;
  end

  // hard stop well beyond the slowest legitimate run
  initial begin
    #4_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // frame building
  // ---------------------------------------------------------------------------
  task automatic add_bytes(input int n);
    repeat (n) frame_q.push_back(8'($urandom));
  endtask

  // addresses, stacked tags, then the ethertype
  task automatic add_eth(input int tags, input logic [15:0] etype);
    add_bytes(ppac_pkg::ETH_TYPE_OFS);
    repeat (tags) begin
      frame_q.push_back(ppac_pkg::ETH_TYPE_VLAN[15:8]);
      frame_q.push_back(ppac_pkg::ETH_TYPE_VLAN[7:0]);
      add_bytes(2);
    end
    frame_q.push_back(etype[15:8]);
    frame_q.push_back(etype[7:0]);
  endtask

  // ip header of ihl words; a short ihl still gets the minimum size behind it
  task automatic add_ipv4(input int ihl, input logic [7:0] proto);
    int hdr;
    hdr = (ihl >= 5) ? ihl * 4 : ppac_pkg::IP_MIN_HDR;
    frame_q.push_back({4'($urandom), 4'(ihl)});
    for (int i = 1; i < hdr; i++) begin
      frame_q.push_back((i == ppac_pkg::IP_PROTO_OFS) ? proto : 8'($urandom));
    end
  endtask

  task automatic add_tcp(input int doff);
    int hdr;
    hdr = (doff >= 5) ? doff * 4 : 20;
    for (int i = 0; i < hdr; i++) begin
      frame_q.push_back((i == ppac_pkg::TCP_DOFF_OFS) ? {4'(doff), 4'($urandom)}
                                                      : 8'($urandom));
    end
  endtask

  // payload where roughly pct percent of the bytes fall in the current range
  task automatic add_payload(input int n, input int pct);
    repeat (n) begin
      if ($urandom_range(0, 99) < pct && sb.print_lo <= sb.print_hi)
        frame_q.push_back(8'($urandom_range(sb.print_hi, sb.print_lo)));
      else
        frame_q.push_back(8'($urandom));
    end
  endtask

  task automatic trim_frame(input int n);
    while (frame_q.size() > n) void'(frame_q.pop_back());
  endtask

  // mostly well-formed frames with random content, some noise and breakage
  task automatic build_random_frame();
    int          roll;
    int          tags;
    int          ihl;
    int          doff;
    int          plen;
    logic [7:0]  proto;
    logic [15:0] etype;
    roll = $urandom_range(0, 99);
    tags = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 3) : 0;
    if (roll < 6) begin
      add_bytes($urandom_range(1, 30));
      return;
    end
    etype = (roll < 12) ? 16'($urandom) : ppac_pkg::ETH_TYPE_IPV4;
    add_eth(tags, etype);
    if (etype != ppac_pkg::ETH_TYPE_IPV4) begin
      add_bytes($urandom_range(0, 20));
      return;
    end
    if ($urandom_range(0, 19) == 0) ihl = $urandom_range(0, 4);
    else ihl = $urandom_range(0, 1) ? 5 : $urandom_range(5, 15);
    roll = $urandom_range(0, 99);
    if (roll < 45) proto = ppac_pkg::IP_PROTO_UDP;
    else if (roll < 90) proto = ppac_pkg::IP_PROTO_TCP;
    else proto = 8'($urandom);
    add_ipv4(ihl, proto);
    if (proto == ppac_pkg::IP_PROTO_UDP) begin
      add_bytes(ppac_pkg::UDP_HDR_LEN);
    end else if (proto == ppac_pkg::IP_PROTO_TCP) begin
      if ($urandom_range(0, 19) == 0) doff = $urandom_range(0, 4);
      else doff = $urandom_range(0, 1) ? 5 : $urandom_range(5, 15);
      add_tcp(doff);
    end
    plen = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 200) : $urandom_range(0, 24);
    add_payload(plen, $urandom_range(0, 100));
    if ($urandom_range(0, 9) == 0) trim_frame($urandom_range(1, frame_q.size()));
  endtask

  // ---------------------------------------------------------------------------
  // byte stream driver: changes at the falling edge, accepts at the rising edge
  // ---------------------------------------------------------------------------
  task automatic send_byte(input logic [7:0] b, input logic last);
    int gap;
    gap = calm ? 0 : $urandom_range(0, MAX_GAP);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i  <= 1'b1;
    data_byte_i <= b;
    last_byte_i <= last;
    do @(posedge clk_i); while (in_stall_o);
    sb.note_byte(b, last);
    @(negedge clk_i);
  endtask

  task automatic send_frame();
    foreach (frame_q[i]) send_byte(frame_q[i], i == frame_q.size() - 1);
    frame_q.delete();
  endtask

  // let every owed verdict come back, then allow for anything still in flight
  task automatic wait_idle();
    in_valid_i <= 1'b0;
    while (sb.pending() != 0) @(negedge clk_i);
    repeat (DRAIN_CYCLES) @(negedge clk_i);
  endtask

  // register write followed by a read back of the same address
  task automatic program_reg(input capper_reg_e idx, input logic [31:0] value);
    logic [31:0] readback;
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= 4'(REG_STRIDE * idx);
    pwdata  <= value;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    sb.set_reg(idx, value);
    @(negedge clk_i);
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    readback = prdata;
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    if (readback != value) begin
      $error("register %0d read back: expected %0d, actual %0d", idx, value, readback);
      sb.errors++;
    end
    @(negedge clk_i);
  endtask

  task automatic apply_config(input logic [7:0] lo, input logic [7:0] hi,
                              input logic [14:0] run, input logic [6:0] pct);
    program_reg(REG_PRINT_LOW, 32'(lo));
    program_reg(REG_PRINT_HIGH, 32'(hi));
    program_reg(REG_RUN_LIMIT, 32'(run));
    program_reg(REG_TEXT_PCT, 32'(pct));
  endtask

  // ---------------------------------------------------------------------------
  // verdict receiver: stall changes at the falling edge
  // a drawn stall only runs down while a verdict is waiting, so every verdict
  // sees its own gap; the long hold-off runs down regardless
  // ---------------------------------------------------------------------------
  initial begin : stall_driver
    int unsigned wait_left;
    bit          hold_active;
    wait_left   = 0;
    hold_active = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        hold_active  = 1'b1;
        wait_left    = LONG_HOLD;
      end else if (took_result && wait_left == 0) begin
        took_result = 1'b0;
        wait_left   = calm ? 0 : $urandom_range(0, MAX_GAP);
      end
      if (wait_left > 0) begin
        out_stall_i <= 1'b1;
        if (hold_active || out_valid_o) wait_left--;
      end else begin
        out_stall_i <= 1'b0;
        hold_active = 1'b0;
      end
    end
  end

  // verdict monitor: a transaction completes on valid high and stall low
  initial begin
    forever begin
      @(posedge clk_i);
      if (rst_ni && out_valid_o && !out_stall_i) begin
        sb.check_verdict(verdict_o, cap_length_o);
        took_result = 1'b1;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // stimulus
  // ---------------------------------------------------------------------------
  initial begin : stimulus
    logic [7:0]  lo_tab  [NUM_PHASES];
    logic [7:0]  hi_tab  [NUM_PHASES];
    logic [14:0] run_tab [NUM_PHASES];
    logic [6:0]  pct_tab [NUM_PHASES];
    int          phase_bytes;
    int          phase_frames;

    // settings: full range, narrow digits, empty range, widest run and share,
    // a single value, capitals, top byte only
    lo_tab  = '{8'd0,   8'd48, 8'd200, 8'd32,     8'd0,  8'd65, 8'd255};
    hi_tab  = '{8'd255, 8'd57, 8'd100, 8'd126,    8'd0,  8'd90, 8'd255};
    run_tab = '{15'd0,  15'd3, 15'd5,  15'd16384, 15'd1, 15'd4, 15'd2};
    pct_tab = '{7'd100, 7'd10, 7'd0,   7'd127,    7'd30, 7'd20, 7'd1};

    // reset held from time zero, released once
    repeat (10) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // directed frames under the reset settings 32..126, run 8, share 50

    // a lone byte, and a frame cut inside its ethertype
    frame_q.push_back(8'h00);
    send_frame();
    add_bytes(13);
    send_frame();
    // non-ip ethertype, then one that differs from ipv4 in its low byte only
    add_eth(0, 16'h86DD);
    add_bytes(6);
    send_frame();
    add_eth(0, 16'h0801);
    add_bytes(2);
    send_frame();
    // nothing but stacked tags
    add_eth(2, ppac_pkg::ETH_TYPE_VLAN);
    send_frame();
    // ihl below the minimum
    add_eth(0, ppac_pkg::ETH_TYPE_IPV4);
    add_ipv4(4, ppac_pkg::IP_PROTO_UDP);
    send_frame();
    // unsupported protocol, complete and cut inside the ip header
    add_eth(1, ppac_pkg::ETH_TYPE_IPV4);
    add_ipv4(5, 8'd1);
    add_bytes(5);
    send_frame();
    add_eth(0, ppac_pkg::ETH_TYPE_IPV4);
    add_ipv4(6, 8'd1);
    trim_frame(30);
    send_frame();
    // udp header reaching exactly the frame end
    add_eth(0, ppac_pkg::ETH_TYPE_IPV4);
    add_ipv4(5, ppac_pkg::IP_PROTO_UDP);
    add_bytes(ppac_pkg::UDP_HDR_LEN);
    send_frame();
    // a single printable payload byte: capped
    add_eth(0, ppac_pkg::ETH_TYPE_IPV4);
    add_ipv4(5, ppac_pkg::IP_PROTO_UDP);
    add_bytes(ppac_pkg::UDP_HDR_LEN);
    frame_q.push_back(8'h41);
    send_frame();
    // range edges, then a run that decides early with bytes trailing behind
    add_eth(0, ppac_pkg::ETH_TYPE_IPV4);
    add_ipv4(5, ppac_pkg::IP_PROTO_UDP);
    add_bytes(ppac_pkg::UDP_HDR_LEN);
    frame_q.push_back(8'd31);
    frame_q.push_back(8'd127);
    frame_q.push_back(8'd32);
    frame_q.push_back(8'd126);
    repeat (6) frame_q.push_back(8'($urandom_range(125, 33)));
    repeat (3) frame_q.push_back(8'hFF);
    send_frame();
    // tcp data offset below the minimum
    add_eth(0, ppac_pkg::ETH_TYPE_IPV4);
    add_ipv4(5, ppac_pkg::IP_PROTO_TCP);
    add_tcp(4);
    add_bytes(4);
    send_frame();
    // largest ip and tcp headers, extreme payload bytes
    add_eth(0, ppac_pkg::ETH_TYPE_IPV4);
    add_ipv4(15, ppac_pkg::IP_PROTO_TCP);
    add_tcp(15);
    frame_q.push_back(8'hFF);
    frame_q.push_back(8'h00);
    send_frame();
    // three tags, tcp, short runs broken up
    add_eth(3, ppac_pkg::ETH_TYPE_IPV4);
    add_ipv4(5, ppac_pkg::IP_PROTO_TCP);
    add_tcp(5);
    for (int i = 0; i < 60; i++) frame_q.push_back((i % 7 == 6) ? 8'h0A : 8'h61 + 8'(i % 7));
    send_frame();
    // runs too short for the run test but enough text for the share test
    add_eth(0, ppac_pkg::ETH_TYPE_IPV4);
    add_ipv4(5, ppac_pkg::IP_PROTO_UDP);
    add_bytes(ppac_pkg::UDP_HDR_LEN);
    for (int i = 0; i < 100; i++) frame_q.push_back((i % 6 == 5) ? 8'h0A : 8'h7A);
    send_frame();
    wait_idle();

    // random frames across several register settings
    for (int p = 0; p < NUM_PHASES; p++) begin
      apply_config(lo_tab[p], hi_tab[p], run_tab[p], pct_tab[p]);
      calm = (p == 4);
      phase_bytes  = 0;
      phase_frames = 0;
      while (phase_bytes < PHASE_BYTES || phase_frames < PHASE_FRAMES) begin
        build_random_frame();
        phase_bytes += frame_q.size();
        phase_frames++;
        send_frame();
      end
      wait_idle();
    end

    // back to the reset settings; the receiver holds off while short frames
    // pour in, so the summary queue fills and the byte stream is stalled
    apply_config(8'd32, 8'd126, 15'd8, 7'd50);
    calm = 1'b1;
    hold_off_req = 1'b1;
    repeat (12) begin
      if ($urandom_range(0, 1)) begin
        add_bytes($urandom_range(1, 6));
      end else begin
        add_eth(0, ppac_pkg::ETH_TYPE_IPV4);
        add_ipv4(5, ppac_pkg::IP_PROTO_UDP);
        add_bytes(ppac_pkg::UDP_HDR_LEN);
        add_payload($urandom_range(1, 4), 50);
      end
      send_frame();
    end
    calm = 1'b0;
    wait_idle();

    repeat (8) @(posedge clk_i);
    if (sb.errors == 0) $display("RESULT: OK");
    else $display("RESULT: ERROR");
    $finish;
  end

endmodule
